// ===== rtl/core/fsnf_pkg.sv =====
// Shared types and constants of the fin set normal force pipeline.
package fsnf_pkg;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_DEGENERATE    = 2'd1,
      STATUS_BAD_GEOMETRY  = 2'd2
   } status_type;

   // pi in unsigned Q2.30, rounded to nearest
   localparam logic [31:0] PI_Q30   = 32'd3373259426;
   localparam int          PI_FRAC  = 30;
   localparam int          SQ_GUARD = 16;

   // radicand is (sumc^2 + 4 s^2 + e^2) << 2*SQ_GUARD, below 2^100
   localparam int X_W    = 68;
   localparam int RAD_W  = X_W + 2 * SQ_GUARD;
   localparam int SQRT_W = RAD_W / 2;
   localparam int T_W    = SQRT_W + 1;

   localparam int QUOT_W = 31;

endpackage

// ===== rtl/core/fsnf_mul.sv =====
// Pipelined wide unsigned multiplier built from 32x32 partial products.
module fsnf_mul #(
   parameter int AW  = 32,
   parameter int BW  = 32,
   parameter int LAT = 2
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic [AW+BW-1:0] p
);

   localparam int NA  = (AW + 31) / 32;
   localparam int NB  = (BW + 31) / 32;
   localparam int RW  = 32 * NA + 32;
   localparam int SW  = 32 * (NA + NB);
   localparam int PAD = LAT - NB - 1;

   logic [32*NA-1:0] a_pad;
   logic [32*NB-1:0] b_pad;
   logic [63:0]      pp_ff   [NB][NA];
   logic [RW-1:0]    ev_c    [NB];
   logic [RW-1:0]    od_c    [NB];
   logic [RW-1:0]    row_in  [NB];
   logic [RW-1:0]    rows_ff [NB][NB];
   logic [SW-1:0]    acc_ff  [NB];

   assign a_pad = (32*NA)'(a);
   assign b_pad = (32*NB)'(b);

   // even and odd partial products of a row do not overlap among themselves
   always_comb begin
      for (int j = 0; j < NB; j++) begin
         ev_c[j] = '0;
         od_c[j] = '0;
         for (int i = 0; i < NA; i++) begin
            if (i % 2 == 0) begin
               ev_c[j][32*i +: 64] = pp_ff[j][i];
            end else begin
               od_c[j][32*i +: 64] = pp_ff[j][i];
            end
         end
         row_in[j] = ev_c[j] + od_c[j];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < NB; j++) begin
            for (int i = 0; i < NA; i++) begin
               pp_ff[j][i] <= 64'(a_pad[32*i +: 32]) * 64'(b_pad[32*j +: 32]);
            end
            rows_ff[0][j] <= row_in[j];
         end
         acc_ff[0] <= SW'(row_in[0]);
         for (int k = 1; k < NB; k++) begin
            for (int j = 0; j < NB; j++) begin
               rows_ff[k][j] <= rows_ff[k-1][j];
            end
            acc_ff[k] <= acc_ff[k-1] + (SW'(rows_ff[k-1][k]) << (32 * k));
         end
      end
   end

   if (PAD == 0) begin : g_nopad
      assign p = acc_ff[NB-1][AW+BW-1:0];
   end else begin : g_pad
      logic [AW+BW-1:0] dly_ff [PAD];
      always_ff @(posedge clock) begin
         if (adv) begin
            dly_ff[0] <= acc_ff[NB-1][AW+BW-1:0];
            for (int i = 1; i < PAD; i++) begin
               dly_ff[i] <= dly_ff[i-1];
            end
         end
      end
      assign p = dly_ff[PAD-1];
   end

endmodule

// ===== rtl/core/fsnf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module fsnf_div #(
   parameter int NW = 64,
   parameter int DW = 32,
   parameter int QW = fsnf_pkg::QUOT_W
) (
   input  logic          clock,
   input  logic          adv,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quot,
   output logic          ovf
);

   localparam int EW = (NW > DW + QW) ? NW : DW + QW;

   logic [EW-1:0] rem_ff  [QW+1];
   logic [DW-1:0] den_ff  [QW+1];
   logic [QW-1:0] q_ff    [QW+1];
   logic          ovf_ff  [QW+1];
   logic [EW-1:0] trial_c [QW+1];
   logic          ge_c    [QW+1];

   always_comb begin
      trial_c[0] = '0;
      ge_c[0]    = 1'b0;
      for (int k = 1; k <= QW; k++) begin
         trial_c[k] = EW'(den_ff[k-1]) << (QW - k);
         ge_c[k]    = rem_ff[k-1] >= trial_c[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= EW'(num);
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         ovf_ff[0] <= EW'(num) >= (EW'(den) << QW);
         for (int k = 1; k <= QW; k++) begin
            rem_ff[k] <= ge_c[k] ? rem_ff[k-1] - trial_c[k] : rem_ff[k-1];
            den_ff[k] <= den_ff[k-1];
            q_ff[k]   <= q_ff[k-1] | (QW'(ge_c[k]) << (QW - k));
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quot = q_ff[QW];
   assign ovf  = ovf_ff[QW];

endmodule

// ===== rtl/core/fin_set_normal_force_and_pressure_center.sv =====
// Barrowman fin set normal force slope and pressure moment, fully pipelined.
//
//  channel | ports  | direction | transaction
//  --------+--------+-----------+-------------------------------------------
//  request | req_*  | in        | one fin set geometry
//  result  | rsp_*  | out       | status, normal slope, pressure moment
//
// One transaction per cycle while the result is not stalled. Stages: input stage, three
// multiplier stages, sum stage, 50-stage square root, T stage, multiplier stages and two
// 32-stage restoring dividers, then the output register.
// Synchronous reset clears only the valid bits.
// A stalled result freezes the whole pipeline; req_ready drops with it.
module fin_set_normal_force_and_pressure_center #(
   parameter int FRAC_BITS = 16,
   parameter int MAX_FINS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_root_chord_len,
   input  logic [31:0]        req_tip_chord_len,
   input  logic [31:0]        req_fin_span,
   input  logic signed [31:0] req_sweep_len,
   input  logic [31:0]        req_body_rad,
   input  logic [4:0]         req_number_of_fins,
   input  logic [31:0]        req_reference_area,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_normal_slope,
   output logic signed [31:0] rsp_pressure_moment
);

   localparam int NFW    = $clog2(MAX_FINS + 1);
   localparam int PNW    = 32 + NFW;
   localparam int KK1W   = PNW + 34;
   localparam int KW     = KK1W + 64;
   localparam int N1W    = KW + 33;
   localparam int N2W    = KW + 66;
   localparam int DW     = 65 + fsnf_pkg::T_W;
   localparam int SQW    = fsnf_pkg::SQRT_W;
   localparam int RADW   = fsnf_pkg::RAD_W;
   localparam int XW     = fsnf_pkg::X_W;
   localparam int TW     = fsnf_pkg::T_W;
   localparam int QW     = fsnf_pkg::QUOT_W;
   localparam int SL_SH  = fsnf_pkg::PI_FRAC - fsnf_pkg::SQ_GUARD;
   localparam int PR_SH  = SL_SH + FRAC_BITS;
   localparam int L1     = 3;
   localparam int L3     = 3;
   localparam int L4     = 4;
   localparam int DEPTH  = 1 + L1 + 1 + SQW + 1 + L3 + L4 + (QW + 1) + 1;

   logic adv;

   logic                 vld_ff [DEPTH];
   fsnf_pkg::status_type sts_ff [DEPTH];
   fsnf_pkg::status_type sts_in;

   assign adv       = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = adv;

   // ---------------- input stage
   logic signed [34:0] e_c;
   logic [32:0]        ae_in;
   logic [NFW-1:0]     nfc_in;

   logic [31:0]     cr_ff, ct_ff, s_ff, a_ff;
   logic [32:0]     sumc_ff, ae_ff, sp1_ff;
   logic [33:0]     sp2_ff;
   logic [PNW-1:0]  pn_ff;

   always_comb begin
      e_c = $signed({{2{req_sweep_len[31]}}, req_sweep_len, 1'b0})
          + $signed({3'b000, req_tip_chord_len})
          - $signed({3'b000, req_root_chord_len});
      ae_in = e_c[34] ? 33'(-e_c) : 33'(e_c);
      if (32'(req_number_of_fins) > 32'(MAX_FINS)) begin
         nfc_in = NFW'(MAX_FINS);
      end else begin
         nfc_in = NFW'(req_number_of_fins);
      end
      priority if (req_reference_area == '0 || req_body_rad == '0) begin
         sts_in = fsnf_pkg::STATUS_DEGENERATE;
      end else if (req_root_chord_len == '0 && req_tip_chord_len == '0) begin
         sts_in = fsnf_pkg::STATUS_BAD_GEOMETRY;
      end else begin
         sts_in = fsnf_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cr_ff   <= req_root_chord_len;
         ct_ff   <= req_tip_chord_len;
         s_ff    <= req_fin_span;
         a_ff    <= req_reference_area;
         sumc_ff <= 33'(req_root_chord_len) + 33'(req_tip_chord_len);
         ae_ff   <= ae_in;
         sp1_ff  <= 33'(req_fin_span) + 33'(req_body_rad);
         sp2_ff  <= 34'(req_fin_span) + {1'b0, req_body_rad, 1'b0};
         pn_ff   <= PNW'(fsnf_pkg::PI_Q30) * PNW'(nfc_in);
      end
   end

   // ---------------- first products
   logic [65:0]       sumc2;
   logic [63:0]       s2;
   logic [65:0]       ae2;
   logic [63:0]       crct;
   logic [64:0]       as_p;
   logic [KK1W-1:0]   kk1;
   logic [32:0]       sumc_p1_ff [L1];

   fsnf_mul #(.AW(33), .BW(33), .LAT(L1)) u_sumc2 (
      .clock(clock), .adv(adv), .a(sumc_ff), .b(sumc_ff), .p(sumc2));
   fsnf_mul #(.AW(32), .BW(32), .LAT(L1)) u_s2 (
      .clock(clock), .adv(adv), .a(s_ff), .b(s_ff), .p(s2));
   fsnf_mul #(.AW(33), .BW(33), .LAT(L1)) u_ae2 (
      .clock(clock), .adv(adv), .a(ae_ff), .b(ae_ff), .p(ae2));
   fsnf_mul #(.AW(32), .BW(32), .LAT(L1)) u_crct (
      .clock(clock), .adv(adv), .a(cr_ff), .b(ct_ff), .p(crct));
   fsnf_mul #(.AW(33), .BW(32), .LAT(L1)) u_as (
      .clock(clock), .adv(adv), .a(sp1_ff), .b(a_ff), .p(as_p));
   fsnf_mul #(.AW(PNW), .BW(34), .LAT(L1)) u_kk1 (
      .clock(clock), .adv(adv), .a(pn_ff), .b(sp2_ff), .p(kk1));

   // ---------------- radicand and chord square sum
   logic [XW-1:0]   x_ff;
   logic [65:0]     q2a_ff;
   logic [KK1W-1:0] kk1_2a_ff;
   logic [63:0]     s2_2a_ff;
   logic [64:0]     as_2a_ff;
   logic [32:0]     sumc_2a_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sumc_p1_ff[0] <= sumc_ff;
         for (int i = 1; i < L1; i++) begin
            sumc_p1_ff[i] <= sumc_p1_ff[i-1];
         end
         x_ff       <= XW'(sumc2) + XW'({s2, 2'b00}) + XW'(ae2);
         // cr^2 + cr*ct + ct^2
         q2a_ff     <= sumc2 - 66'(crct);
         kk1_2a_ff  <= kk1;
         s2_2a_ff   <= s2;
         as_2a_ff   <= as_p;
         sumc_2a_ff <= sumc_p1_ff[L1-1];
      end
   end

   // ---------------- square root, one root bit per stage
   logic [RADW-1:0] sq_rem_ff  [SQW];
   logic [SQW-1:0]  sq_root_ff [SQW];
   logic [RADW-1:0] rem_src    [SQW];
   logic [SQW-1:0]  root_src   [SQW];
   logic [RADW-1:0] trial_c    [SQW];
   logic            ge_c       [SQW];

   logic [KK1W-1:0] kk1_sq_ff  [SQW];
   logic [63:0]     s2_sq_ff   [SQW];
   logic [64:0]     as_sq_ff   [SQW];
   logic [32:0]     sumc_sq_ff [SQW];
   logic [65:0]     q_sq_ff    [SQW];

   always_comb begin
      rem_src[0]  = {x_ff, {(2*fsnf_pkg::SQ_GUARD){1'b0}}};
      root_src[0] = '0;
      for (int j = 1; j < SQW; j++) begin
         rem_src[j]  = sq_rem_ff[j-1];
         root_src[j] = sq_root_ff[j-1];
      end
      // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
      for (int j = 0; j < SQW; j++) begin
         trial_c[j] = (RADW'(root_src[j]) << (SQW - j))
                    + (RADW'(1) << (2 * (SQW - 1 - j)));
         ge_c[j]    = rem_src[j] >= trial_c[j];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < SQW; j++) begin
            sq_rem_ff[j]  <= ge_c[j] ? rem_src[j] - trial_c[j] : rem_src[j];
            sq_root_ff[j] <= root_src[j] | (SQW'(ge_c[j]) << (SQW - 1 - j));
         end
         kk1_sq_ff[0]  <= kk1_2a_ff;
         s2_sq_ff[0]   <= s2_2a_ff;
         as_sq_ff[0]   <= as_2a_ff;
         sumc_sq_ff[0] <= sumc_2a_ff;
         q_sq_ff[0]    <= q2a_ff;
         for (int j = 1; j < SQW; j++) begin
            kk1_sq_ff[j]  <= kk1_sq_ff[j-1];
            s2_sq_ff[j]   <= s2_sq_ff[j-1];
            as_sq_ff[j]   <= as_sq_ff[j-1];
            sumc_sq_ff[j] <= sumc_sq_ff[j-1];
            q_sq_ff[j]    <= q_sq_ff[j-1];
         end
      end
   end

   // ---------------- T = sumc * 2^16 + root
   logic [TW-1:0]   t_ff;
   logic [KK1W-1:0] kk1_t_ff;
   logic [63:0]     s2_t_ff;
   logic [64:0]     as_t_ff;
   logic [32:0]     sumc_t_ff;
   logic [65:0]     q_t_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff      <= TW'({sumc_sq_ff[SQW-1], {fsnf_pkg::SQ_GUARD{1'b0}}})
                    + TW'(sq_root_ff[SQW-1]);
         kk1_t_ff  <= kk1_sq_ff[SQW-1];
         s2_t_ff   <= s2_sq_ff[SQW-1];
         as_t_ff   <= as_sq_ff[SQW-1];
         sumc_t_ff <= sumc_sq_ff[SQW-1];
         q_t_ff    <= q_sq_ff[SQW-1];
      end
   end

   // ---------------- common factor and divisor
   logic [KW-1:0] k_p;
   logic [DW-1:0] d_p;
   logic [32:0]   sumc_p3_ff [L3];
   logic [65:0]   q_p3_ff    [L3];

   fsnf_mul #(.AW(KK1W), .BW(64), .LAT(L3)) u_k (
      .clock(clock), .adv(adv), .a(kk1_t_ff), .b(s2_t_ff), .p(k_p));
   fsnf_mul #(.AW(65), .BW(TW), .LAT(L3)) u_d (
      .clock(clock), .adv(adv), .a(as_t_ff), .b(t_ff), .p(d_p));

   // ---------------- numerators
   logic [N1W-1:0]  n1;
   logic [N2W-1:0]  n2;
   logic [DW-1:0]   d_p4_ff  [L4];
   logic [DW+2:0]   d6_p4_ff [L4];

   fsnf_mul #(.AW(KW), .BW(33), .LAT(L4)) u_n1 (
      .clock(clock), .adv(adv), .a(k_p), .b(sumc_p3_ff[L3-1]), .p(n1));
   fsnf_mul #(.AW(KW), .BW(66), .LAT(L4)) u_n2 (
      .clock(clock), .adv(adv), .a(k_p), .b(q_p3_ff[L3-1]), .p(n2));

   always_ff @(posedge clock) begin
      if (adv) begin
         sumc_p3_ff[0] <= sumc_t_ff;
         q_p3_ff[0]    <= q_t_ff;
         for (int i = 1; i < L3; i++) begin
            sumc_p3_ff[i] <= sumc_p3_ff[i-1];
            q_p3_ff[i]    <= q_p3_ff[i-1];
         end
         d_p4_ff[0]  <= d_p;
         d6_p4_ff[0] <= ((DW+3)'(d_p) << 2) + ((DW+3)'(d_p) << 1);
         for (int i = 1; i < L4; i++) begin
            d_p4_ff[i]  <= d_p4_ff[i-1];
            d6_p4_ff[i] <= d6_p4_ff[i-1];
         end
      end
   end

   // ---------------- quotients
   logic [QW-1:0] q1, q2;
   logic          ovf1, ovf2;

   fsnf_div #(.NW(N1W - SL_SH), .DW(DW), .QW(QW)) u_div_slope (
      .clock(clock), .adv(adv), .num(n1[N1W-1:SL_SH]), .den(d_p4_ff[L4-1]),
      .quot(q1), .ovf(ovf1));
   fsnf_div #(.NW(N2W - PR_SH), .DW(DW + 3), .QW(QW)) u_div_moment (
      .clock(clock), .adv(adv), .num(n2[N2W-1:PR_SH]), .den(d6_p4_ff[L4-1]),
      .quot(q2), .ovf(ovf2));

   // ---------------- output register
   logic signed [31:0] slope_ff, pres_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (sts_ff[DEPTH-2] != fsnf_pkg::STATUS_OK) begin
            slope_ff <= '0;
            pres_ff  <= '0;
         end else begin
            slope_ff <= ovf1 ? 32'sh7FFF_FFFF : $signed({1'b0, q1});
            pres_ff  <= ovf2 ? 32'sh8000_0000 : -$signed({1'b0, q2});
         end
      end
   end

   // valid bits and status travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < DEPTH; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sts_ff[0] <= sts_in;
         for (int i = 1; i < DEPTH; i++) begin
            sts_ff[i] <= sts_ff[i-1];
         end
      end
   end

   assign rsp_valid           = vld_ff[DEPTH-1];
   assign rsp_status          = sts_ff[DEPTH-1];
   assign rsp_normal_slope    = slope_ff;
   assign rsp_pressure_moment = pres_ff;

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the fin set normal force and pressure moment pipeline.
`timescale 1ns / 1ps

module tb;

   localparam int FRAC_BITS = 16;
   localparam int MAX_FINS  = 16;
   localparam int LATENCY   = 96;

   typedef struct {
      logic [31:0]        cr;
      logic [31:0]        ct;
      logic [31:0]        span;
      logic signed [31:0] sweep;
      logic [31:0]        rb;
      logic [4:0]         nf;
      logic [31:0]        area;
   } fin_geom_type;

   typedef struct {
      fsnf_pkg::status_type status;
      logic signed [31:0]   slope;
      logic signed [31:0]   moment;
   } fin_forces_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [31:0]        req_root_chord_len = '0;
   logic [31:0]        req_tip_chord_len = '0;
   logic [31:0]        req_fin_span = '0;
   logic signed [31:0] req_sweep_len = '0;
   logic [31:0]        req_body_rad = '0;
   logic [4:0]         req_number_of_fins = '0;
   logic [31:0]        req_reference_area = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_normal_slope;
   logic signed [31:0] rsp_pressure_moment;

   fin_geom_type   geom_queue[$];
   fin_forces_type forces_queue[$];
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;
   int             error_count = 0;

   fin_set_normal_force_and_pressure_center #(
      .FRAC_BITS(FRAC_BITS),
      .MAX_FINS (MAX_FINS)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_root_chord_len (req_root_chord_len),
      .req_tip_chord_len  (req_tip_chord_len),
      .req_fin_span       (req_fin_span),
      .req_sweep_len      (req_sweep_len),
      .req_body_rad       (req_body_rad),
      .req_number_of_fins (req_number_of_fins),
      .req_reference_area (req_reference_area),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_normal_slope   (rsp_normal_slope),
      .rsp_pressure_moment(rsp_pressure_moment)
   );

   always #5 clock = ~clock;

   // Exact Barrowman evaluation with wide integers
   function automatic fin_forces_type barrowman_forces(fin_geom_type g);
      fin_forces_type   f;
      logic [255:0]     sumc, span, ae, rad, root, cand, tsum, common, den, quo;
      logic signed [34:0] e;
      logic [255:0]     nfc;
      f.status = fsnf_pkg::STATUS_OK;
      f.slope  = '0;
      f.moment = '0;
      if (g.area == 0 || g.rb == 0) begin
         f.status = fsnf_pkg::STATUS_DEGENERATE;
         return f;
      end
      sumc = 256'(g.cr) + 256'(g.ct);
      if (sumc == 0) begin
         f.status = fsnf_pkg::STATUS_BAD_GEOMETRY;
         return f;
      end
      nfc  = (g.nf > MAX_FINS) ? 256'(MAX_FINS) : 256'(g.nf);
      span = 256'(g.span);
      e    = (35'(g.sweep) <<< 1) + $signed({3'b0, g.ct}) - $signed({3'b0, g.cr});
      ae   = 256'(e < 0 ? -e : e);
      rad  = (sumc * sumc + 4 * span * span + ae * ae) << (2 * fsnf_pkg::SQ_GUARD);
      root = '0;
      for (int b = 52; b >= 0; b--) begin
         cand = root | (256'd1 << b);
         if (cand * cand <= rad) root = cand;
      end
      tsum   = (sumc << fsnf_pkg::SQ_GUARD) + root;
      common = (256'(fsnf_pkg::PI_Q30) * nfc * span * span * (span + 2 * 256'(g.rb)))
               << fsnf_pkg::SQ_GUARD;
      den    = 256'(g.area) * (span + 256'(g.rb)) * tsum;
      quo    = (common * sumc) / (den << fsnf_pkg::PI_FRAC);
      f.slope = (quo > 256'h7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
      quo = (common * (256'(g.cr) * g.cr + 256'(g.cr) * g.ct + 256'(g.ct) * g.ct))
            / ((den * 6) << (fsnf_pkg::PI_FRAC + FRAC_BITS));
      f.moment = (quo >= 256'h8000_0000) ? 32'sh8000_0000 : -quo[31:0];
      return f;
   endfunction

   // Mix of full range, modest and tiny magnitudes
   function automatic logic [31:0] pick_len();
      unique case ($urandom_range(0, 9))
         0, 1:    return $urandom();
         2:       return $urandom_range(0, 3);
         3:       return 32'hFFFF_FFFF >> $urandom_range(0, 31);
         default: return $urandom() >> $urandom_range(8, 20);
      endcase
   endfunction

   function automatic fin_geom_type random_geom();
      fin_geom_type g;
      g.cr    = pick_len();
      g.ct    = ($urandom_range(0, 9) == 0) ? 32'd0 : pick_len();
      g.span  = pick_len();
      g.sweep = ($urandom_range(0, 1) == 1) ? $urandom() : pick_len() >>> 1;
      if ($urandom_range(0, 3) == 0) g.sweep = -g.sweep;
      g.rb    = ($urandom_range(0, 39) == 0) ? 32'd0 : pick_len();
      g.nf    = ($urandom_range(0, 4) == 0) ? 5'($urandom()) : 5'($urandom_range(1, 16));
      g.area  = ($urandom_range(0, 39) == 0) ? 32'd0 : pick_len();
      if ($urandom_range(0, 29) == 0) begin
         g.cr = '0;
         g.ct = '0;
      end
      return g;
   endfunction

   function automatic fin_geom_type make_geom(logic [31:0] cr, logic [31:0] ct,
                                              logic [31:0] span, logic [31:0] sweep,
                                              logic [31:0] rb, logic [4:0] nf,
                                              logic [31:0] area);
      fin_geom_type g;
      g.cr = cr; g.ct = ct; g.span = span; g.sweep = sweep;
      g.rb = rb; g.nf = nf; g.area = area;
      return g;
   endfunction

   // Driver: predicts on each accepted transaction and loads the next one
   always @(posedge clock) begin
      fin_geom_type g;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            g.cr = req_root_chord_len; g.ct = req_tip_chord_len; g.span = req_fin_span;
            g.sweep = req_sweep_len; g.rb = req_body_rad; g.nf = req_number_of_fins;
            g.area = req_reference_area;
            forces_queue.push_back(barrowman_forces(g));
         end
         if (!req_valid || req_ready) begin
            if (geom_queue.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
               g = geom_queue.pop_front();
               req_valid          <= 1'b1;
               req_root_chord_len <= g.cr;
               req_tip_chord_len  <= g.ct;
               req_fin_span       <= g.span;
               req_sweep_len      <= g.sweep;
               req_body_rad       <= g.rb;
               req_number_of_fins <= g.nf;
               req_reference_area <= g.area;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random backpressure and in-order comparison
   always @(posedge clock) begin
      fin_forces_type f;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (forces_queue.size() == 0) begin
               $display("%0t: unexpected result status=%0d slope=%h moment=%h", $time,
                        rsp_status, rsp_normal_slope, rsp_pressure_moment);
               error_count++;
            end else begin
               f = forces_queue.pop_front();
               if (rsp_status !== f.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, f.status, rsp_status);
                  error_count++;
               end
               if (rsp_normal_slope !== f.slope) begin
                  $display("%0t: normal_slope expected %h actual %h", $time, f.slope,
                           rsp_normal_slope);
                  error_count++;
               end
               if (rsp_pressure_moment !== f.moment) begin
                  $display("%0t: pressure_moment expected %h actual %h", $time, f.moment,
                           rsp_pressure_moment);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(1, 100) > recv_stall_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      geom_queue.push_back(make_geom(32'h0001_0000, 32'h0000_8000, 32'h0000_C000,
                                     32'h0000_4000, 32'h0000_4000, 5'd4, 32'h0000_3244));
      geom_queue.push_back(make_geom(32'h0001_0000, 32'h0000_8000, 32'h0000_C000,
                                     32'h0000_4000, 32'h0000_4000, 5'd4, 32'd0));
      geom_queue.push_back(make_geom(32'h0001_0000, 32'h0000_8000, 32'h0000_C000,
                                     32'h0000_4000, 32'd0, 5'd4, 32'h0001_0000));
      geom_queue.push_back(make_geom(32'd0, 32'd0, 32'h0000_C000, 32'h0000_4000,
                                     32'h0000_4000, 5'd3, 32'h0001_0000));
      geom_queue.push_back(make_geom(32'd0, 32'd0, 32'h0000_C000, 32'h0, 32'd0, 5'd3, 32'd0));
      geom_queue.push_back(make_geom(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                     32'h0, 32'h0000_2000, 5'd0, 32'h0001_0000));
      geom_queue.push_back(make_geom(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                     32'h0, 32'h0000_2000, 5'd31, 32'h0001_0000));
      geom_queue.push_back(make_geom(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                     32'h0, 32'h0000_2000, 5'd16, 32'h0001_0000));
      geom_queue.push_back(make_geom(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                     32'h0, 32'h0000_2000, 5'd17, 32'h0001_0000));
      geom_queue.push_back(make_geom(32'h0001_0000, 32'h0000_8000, 32'd0, 32'h0000_4000,
                                     32'h0000_4000, 5'd4, 32'h0001_0000));
      geom_queue.push_back(make_geom('1, '1, '1, 32'h7FFF_FFFF, '1, 5'd16, 32'd1));
      geom_queue.push_back(make_geom('1, '1, '1, 32'h8000_0000, '1, 5'd16, '1));
      geom_queue.push_back(make_geom(32'd1, 32'd0, 32'd1, 32'h8000_0000, 32'd1, 5'd1, '1));
      geom_queue.push_back(make_geom(32'd0, 32'd1, '1, 32'hFFFF_FFFF, 32'd1, 5'd1, 32'd1));
      geom_queue.push_back(make_geom(32'h0000_0100, 32'h0000_0100, 32'h0000_0100, 32'd0,
                                     32'h0000_0100, 5'd2, '1));
      geom_queue.push_back(make_geom(32'h0010_0000, 32'h0001_0000, 32'h0008_0000,
                                     32'hFFF0_0000, 32'h0000_8000, 5'd8, 32'h0000_0100));

      for (int phase = 0; phase < 4; phase++) begin
         unique case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         for (int n = 0; n < 375; n++) geom_queue.push_back(random_geom());
         // hold off until the pipeline has fully drained
         while (geom_queue.size() > 0 || req_valid || forces_queue.size() > 0)
            @(posedge clock);
      end

      repeat (2 * LATENCY) @(posedge clock);
      if (error_count == 0 && forces_queue.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
